[rtl/jtl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jtl_pkg;

	// Token kinds as they appear on token_kind.
	localparam logic [3:0] K_LBRACE   = 4'd0;
	localparam logic [3:0] K_RBRACE   = 4'd1;
	localparam logic [3:0] K_LBRACKET = 4'd2;
	localparam logic [3:0] K_RBRACKET = 4'd3;
	localparam logic [3:0] K_COLON    = 4'd4;
	localparam logic [3:0] K_COMMA    = 4'd5;
	localparam logic [3:0] K_STRING   = 4'd6;
	localparam logic [3:0] K_NUMBER   = 4'd7;
	localparam logic [3:0] K_TRUE     = 4'd8;
	localparam logic [3:0] K_EOF      = 4'd11;
	localparam logic [3:0] K_ERROR    = 4'd12;

	// Literal word selectors.
	localparam logic [1:0] W_TRUE  = 2'd0;
	localparam logic [1:0] W_FALSE = 2'd1;
	localparam logic [1:0] W_NULL  = 2'd2;

	// Number grammar phases.
	localparam logic [1:0] P_INT  = 2'd0;
	localparam logic [1:0] P_FRAC = 2'd1;
	localparam logic [1:0] P_EXP0 = 2'd2;
	localparam logic [1:0] P_EXP  = 2'd3;

	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		M_START   = 3'd0,
		M_STRING  = 3'd1,
		M_ESCAPE  = 3'd2,
		M_HEX     = 3'd3,
		M_LITERAL = 3'd4,
		M_NUMBER  = 3'd5,
		M_ERROR   = 3'd6
	} mode_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic       content;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0]                n;
		result_t [MAX_RES-1:0]     r;
	} bundle_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] hex;
		logic [1:0]  hcnt;
		logic [1:0]  lw;
		logic [2:0]  li;
		logic [1:0]  phase;
	} state_t;

	typedef struct packed {
		state_t  s;
		bundle_t b;
	} lex_t;

	function automatic logic [2:0] word_len(input logic [1:0] w);
		return (w == W_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] ch;
		ch = 8'h00;
		case (w)
			W_FALSE: begin
				case (i)
					3'd0: ch = 8'h66;
					3'd1: ch = 8'h61;
					3'd2: ch = 8'h6C;
					3'd3: ch = 8'h73;
					3'd4: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			W_NULL: begin
				case (i)
					3'd0: ch = 8'h6E;
					3'd1: ch = 8'h75;
					3'd2: ch = 8'h6C;
					3'd3: ch = 8'h6C;
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (i)
					3'd0: ch = 8'h74;
					3'd1: ch = 8'h72;
					3'd2: ch = 8'h75;
					3'd3: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

[rtl/jtl_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module jtl_step (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       in_byte,
	input  wire logic             end_of_input,
	output jtl_pkg::bundle_t      bundle
);
	import jtl_pkg::*;

	localparam state_t STATE_RESET = '{mode: M_START, hex: 16'h0, hcnt: 2'd0,
		lw: 2'd0, li: 3'd0, phase: 2'd0};

	state_t state_q;
	lex_t   x;

	function automatic lex_t emit(input lex_t a, input logic [3:0] k, input logic [7:0] d,
		input logic c);
		lex_t y;
		y = a;
		if (y.b.n < 2'(MAX_RES)) begin
			y.b.r[y.b.n] = '{kind: k, data: d, content: c, last: 1'b0};
			y.b.n = y.b.n + 2'd1;
		end
		return y;
	endfunction

	function automatic lex_t go_error(input lex_t a);
		lex_t y;
		y = emit(a, K_ERROR, 8'h00, 1'b0);
		y.s.mode = M_ERROR;
		return y;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic lex_t lex_start(input lex_t a, input logic [7:0] c);
		lex_t y;
		y = a;
		case (c) inside
			8'h20, 8'h09, 8'h0A, 8'h0D: ;
			8'h7B: y = emit(y, K_LBRACE, 8'h00, 1'b0);
			8'h7D: y = emit(y, K_RBRACE, 8'h00, 1'b0);
			8'h5B: y = emit(y, K_LBRACKET, 8'h00, 1'b0);
			8'h5D: y = emit(y, K_RBRACKET, 8'h00, 1'b0);
			8'h3A: y = emit(y, K_COLON, 8'h00, 1'b0);
			8'h2C: y = emit(y, K_COMMA, 8'h00, 1'b0);
			8'h22: y.s.mode = M_STRING;
			8'h74, 8'h66, 8'h6E: begin
				y.s.lw = (c == 8'h74) ? W_TRUE : (c == 8'h66) ? W_FALSE : W_NULL;
				y.s.li = 3'd1;
				y.s.mode = M_LITERAL;
			end
			8'h2D, [8'h30:8'h39]: begin
				y.s.phase = P_INT;
				y.s.mode = M_NUMBER;
				y = emit(y, K_NUMBER, c, 1'b1);
			end
			default: y = go_error(y);
		endcase
		return y;
	endfunction

	always_comb begin
		logic [7:0]  c;
		logic        e_char;
		logic        takes;
		logic [1:0]  nphase;
		logic [3:0]  nib;
		logic        nib_ok;
		logic [15:0] cp;
		logic [1:0]  w;
		logic [2:0]  len;
		logic [2:0]  nli;
		logic [7:0]  v;
		c      = in_byte;
		e_char = (c == 8'h65) || (c == 8'h45);
		takes  = 1'b0;
		nphase = state_q.phase;
		nib    = 4'h0;
		nib_ok = 1'b1;
		cp     = 16'h0;
		w      = (state_q.lw == 2'd3) ? W_TRUE : state_q.lw;
		len    = word_len(w);
		nli    = state_q.li + 3'd1;
		v      = c;
		x.s    = state_q;
		x.b    = '0;

		if (end_of_input) begin
			case (state_q.mode)
				M_NUMBER: x = emit(x, K_NUMBER, 8'h00, 1'b0);
				M_STRING, M_ESCAPE, M_HEX, M_LITERAL: x = emit(x, K_ERROR, 8'h00, 1'b0);
				default: ;
			endcase
			x = emit(x, K_EOF, 8'h00, 1'b0);
			x.s = STATE_RESET;
		end else begin
			case (state_q.mode)
				M_START: x = lex_start(x, c);
				M_STRING: begin
					if (c == 8'h22) begin
						x = emit(x, K_STRING, 8'h00, 1'b0);
						x.s.mode = M_START;
					end else if (c == 8'h5C) begin
						x.s.mode = M_ESCAPE;
					end else begin
						x = emit(x, K_STRING, c, 1'b1);
					end
				end
				M_ESCAPE: begin
					if (c == 8'h75) begin
						x.s.hex  = 16'h0;
						x.s.hcnt = 2'd0;
						x.s.mode = M_HEX;
					end else begin
						case (c)
							8'h62: v = 8'h08;
							8'h66: v = 8'h0C;
							8'h6E: v = 8'h0A;
							8'h72: v = 8'h0D;
							8'h74: v = 8'h09;
							default: v = c;
						endcase
						x = emit(x, K_STRING, v, 1'b1);
						x.s.mode = M_STRING;
					end
				end
				M_HEX: begin
					if (is_digit(c)) begin
						nib = c[3:0];
					end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
						nib = c[3:0] + 4'd9;
					end else begin
						nib_ok = 1'b0;
					end
					if (!nib_ok) begin
						x = go_error(x);
					end else begin
						cp = {state_q.hex[11:0], nib};
						x.s.hex = cp;
						if (state_q.hcnt == 2'd3) begin
							x.s.hcnt = 2'd0;
							x.s.mode = M_STRING;
							if (cp < 16'h0080) begin
								x = emit(x, K_STRING, cp[7:0], 1'b1);
							end else if (cp < 16'h0800) begin
								x = emit(x, K_STRING, {3'b110, cp[10:6]}, 1'b1);
								x = emit(x, K_STRING, {2'b10, cp[5:0]}, 1'b1);
							end else begin
								x = emit(x, K_STRING, {4'b1110, cp[15:12]}, 1'b1);
								x = emit(x, K_STRING, {2'b10, cp[11:6]}, 1'b1);
								x = emit(x, K_STRING, {2'b10, cp[5:0]}, 1'b1);
							end
						end else begin
							x.s.hcnt = state_q.hcnt + 2'd1;
						end
					end
				end
				M_LITERAL: begin
					if (state_q.li >= len || word_char(w, state_q.li) != c) begin
						x = go_error(x);
					end else begin
						x.s.li = nli;
						if (nli >= len) begin
							x = emit(x, K_TRUE + {2'b00, w}, 8'h00, 1'b0);
							x.s.mode = M_START;
						end
					end
				end
				M_NUMBER: begin
					case (state_q.phase)
						P_INT: begin
							takes = is_digit(c) || c == 8'h2E || e_char;
							nphase = (c == 8'h2E) ? P_FRAC : e_char ? P_EXP0 : P_INT;
						end
						P_FRAC: begin
							takes = is_digit(c) || e_char;
							nphase = e_char ? P_EXP0 : P_FRAC;
						end
						P_EXP0: begin
							takes = is_digit(c) || c == 8'h2B || c == 8'h2D;
							nphase = P_EXP;
						end
						default: begin
							takes = is_digit(c);
							nphase = P_EXP;
						end
					endcase
					if (takes) begin
						x.s.phase = nphase;
						x = emit(x, K_NUMBER, c, 1'b1);
					end else begin
						// The byte that ends a number is lexed again as a fresh start.
						x = emit(x, K_NUMBER, 8'h00, 1'b0);
						x.s.mode  = M_START;
						x.s.phase = P_INT;
						x = lex_start(x, c);
					end
				end
				default: ;
			endcase
		end

		for (int i = 0; i < MAX_RES; i++) begin
			x.b.r[i].last = (x.b.n != 2'd0) && (2'(i) == x.b.n - 2'd1);
		end
	end

	assign bundle = x.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= x.s;
		end
	end

endmodule

`default_nettype wire

[rtl/jtl_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module jtl_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire jtl_pkg::bundle_t bundle,
	output logic                  room,
	input  wire logic             pop,
	output logic                  head_valid,
	output jtl_pkg::result_t      head
);
	import jtl_pkg::*;

	result_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_q;
	logic [FIFO_AW-1:0]     rd_q;
	logic [FIFO_AW:0]       count_q;
	logic [FIFO_AW:0]       n_push;
	logic                   do_pop;

	// A whole beat group from one item must fit, so room means a full set of free slots.
	assign room       = count_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;
	assign n_push     = push ? (FIFO_AW+1)'(bundle.n) : '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (push && (2'(i) < bundle.n)) begin
				mem_q[wr_q + FIFO_AW'(i)] <= bundle.r[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[FIFO_AW-1:0];
			rd_q    <= rd_q + FIFO_AW'(do_pop);
			count_q <= count_q + n_push - (FIFO_AW+1)'(do_pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && bundle.n != 2'd0 |-> room)
		else $error("results pushed without room for a full group");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> count_q == $past(count_q) + $past(n_push))
		else $error("result queue count does not follow pushes");

	a_group_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && bundle.n != 2'd0 |-> bundle.r[bundle.n - 2'd1].last)
		else $error("pushed group does not end with a last beat");
`endif

endmodule

`default_nettype wire

[rtl/json_token_lexer_top.sv]
// Streaming JSON lexer, one text byte per input beat.
// Input channel: in_valid / in_stall with in_byte and end_of_input. A beat with
// end_of_input set closes the document: a pending number or an unfinished token
// is reported, an eof token follows, and the lexer returns to its start state.
// Output channel: out_valid / out_stall with token_kind, data_byte, is_content
// and last. One input beat yields zero to three output beats; last marks the
// final one of that group.
// Throughput: one input beat per cycle while in_stall is low. The lexer step
// computes a beat's results combinationally from its state register; they
// enter an eight-entry queue when the beat is accepted and drain one per cycle
// while out_stall is low. in_stall rises while fewer than three queue slots
// are free, so a run of multi-result beats (a \u escape, a number end) can hold the input back.
// When the receiver stalls, queued results hold and input continues to be
// taken until the queue is nearly full.
// Reset (arst_n low) returns the lexer to the start state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module json_token_lexer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [3:0]      token_kind,
	output logic [7:0]      data_byte,
	output logic            is_content,
	output logic            last
);
	import jtl_pkg::*;

	bundle_t bundle;
	result_t head;
	logic    room;
	logic    accept;

	assign in_stall = !room;
	assign accept   = in_valid && room;

	jtl_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.bundle       (bundle)
	);

	jtl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.bundle     (bundle),
		.room       (room),
		.pop        (!out_stall),
		.head_valid (out_valid),
		.head       (head)
	);

	assign token_kind = head.kind;
	assign data_byte  = head.data;
	assign is_content = head.content;
	assign last       = head.last;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import jtl_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_input;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] token_kind;
	logic [7:0] data_byte;
	logic       is_content;
	logic       last;

	json_token_lexer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.data_byte(data_byte),
		.is_content(is_content),
		.last(last)
	);

	localparam bit TYPED     = 1'b1;
	localparam bit PREDICTED = 1'b0;
	localparam int TOTAL_BEATS = 480;

	typedef struct packed {
		logic [7:0] text;
		logic       eoi;
		bit         typed;
		logic [3:0] kind;
		logic [7:0] data;
		logic       content;
	} script_row_t;

	// Lexer state as the checker sees it.
	mode_t       lx_mode;
	logic [15:0] esc_code;
	logic [2:0]  esc_digits;
	logic [1:0]  kw_sel;
	logic [2:0]  kw_pos;
	logic [1:0]  num_phase;

	string kw_text [3] = '{"true", "false", "null"};

	result_t beat_tokens [$];
	result_t pending_tokens [$];
	logic [8:0] doc_q [$];

	bit      use_typed;
	result_t typed_res;
	bit      draining;

	int errors;
	int beats_sent;
	int tokens_checked;
	int eof_seen;
	int error_tokens;
	int documents;

	script_row_t script [0:25];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic void put_token(input logic [3:0] k, input logic [7:0] d,
			input logic c);
		result_t r;
		r.kind = k;
		r.data = d;
		r.content = c;
		r.last = 1'b0;
		beat_tokens = {beat_tokens, r};
	endfunction

	function automatic void clear_lexer();
		lx_mode = M_START;
		esc_code = '0;
		esc_digits = '0;
		kw_sel = '0;
		kw_pos = '0;
		num_phase = P_INT;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void raise_error();
		put_token(K_ERROR, 8'h00, 1'b0);
		lx_mode = M_ERROR;
	endfunction

	function automatic void lex_begin(input logic [7:0] c);
		case (c)
			" ", 8'h09, 8'h0A, 8'h0D: ;
			"{": put_token(K_LBRACE, 8'h00, 1'b0);
			"}": put_token(K_RBRACE, 8'h00, 1'b0);
			"[": put_token(K_LBRACKET, 8'h00, 1'b0);
			"]": put_token(K_RBRACKET, 8'h00, 1'b0);
			":": put_token(K_COLON, 8'h00, 1'b0);
			",": put_token(K_COMMA, 8'h00, 1'b0);
			8'h22: lx_mode = M_STRING;
			"t", "f", "n": begin
				kw_sel = (c == "t") ? W_TRUE : (c == "f") ? W_FALSE : W_NULL;
				kw_pos = 3'd1;
				lx_mode = M_LITERAL;
			end
			default: begin
				if (c == "-" || is_digit(c)) begin
					num_phase = P_INT;
					lx_mode = M_NUMBER;
					put_token(K_NUMBER, c, 1'b1);
				end else begin
					raise_error();
				end
			end
		endcase
	endfunction

	function automatic bit number_fits(input logic [7:0] c);
		bit expo;
		expo = (c == "e" || c == "E");
		case (num_phase)
			P_INT: begin
				if (is_digit(c)) return 1'b1;
				if (c == ".") begin
					num_phase = P_FRAC;
					return 1'b1;
				end
				if (expo) begin
					num_phase = P_EXP0;
					return 1'b1;
				end
				return 1'b0;
			end
			P_FRAC: begin
				if (is_digit(c)) return 1'b1;
				if (expo) begin
					num_phase = P_EXP0;
					return 1'b1;
				end
				return 1'b0;
			end
			P_EXP0: begin
				if (is_digit(c) || c == "+" || c == "-") begin
					num_phase = P_EXP;
					return 1'b1;
				end
				return 1'b0;
			end
			default: return is_digit(c);
		endcase
	endfunction

	function automatic void emit_utf8(input logic [15:0] cp);
		if (cp < 16'h0080) begin
			put_token(K_STRING, cp[7:0], 1'b1);
		end else if (cp < 16'h0800) begin
			put_token(K_STRING, 8'hC0 | {3'b000, cp[10:6]}, 1'b1);
			put_token(K_STRING, 8'h80 | {2'b00, cp[5:0]}, 1'b1);
		end else begin
			put_token(K_STRING, 8'hE0 | {4'h0, cp[15:12]}, 1'b1);
			put_token(K_STRING, 8'h80 | {2'b00, cp[11:6]}, 1'b1);
			put_token(K_STRING, 8'h80 | {2'b00, cp[5:0]}, 1'b1);
		end
	endfunction

	function automatic void lex_char(input logic [7:0] c);
		logic [7:0] v;
		int nib;
		case (lx_mode)
			M_START: lex_begin(c);
			M_STRING: begin
				if (c == 8'h22) begin
					put_token(K_STRING, 8'h00, 1'b0);
					lx_mode = M_START;
				end else if (c == 8'h5C) begin
					lx_mode = M_ESCAPE;
				end else begin
					put_token(K_STRING, c, 1'b1);
				end
			end
			M_ESCAPE: begin
				if (c == "u") begin
					esc_code = '0;
					esc_digits = '0;
					lx_mode = M_HEX;
				end else begin
					case (c)
						"b": v = 8'h08;
						"f": v = 8'h0C;
						"n": v = 8'h0A;
						"r": v = 8'h0D;
						"t": v = 8'h09;
						default: v = c;
					endcase
					put_token(K_STRING, v, 1'b1);
					lx_mode = M_STRING;
				end
			end
			M_HEX: begin
				nib = hex_nibble(c);
				if (nib < 0) begin
					raise_error();
				end else begin
					esc_code = {esc_code[11:0], 4'(nib)};
					esc_digits = esc_digits + 3'd1;
					if (esc_digits >= 3'd4) begin
						emit_utf8(esc_code);
						esc_digits = '0;
						lx_mode = M_STRING;
					end
				end
			end
			M_LITERAL: begin
				if (kw_pos >= kw_text[kw_sel].len() || kw_text[kw_sel][kw_pos] != c) begin
					raise_error();
				end else begin
					kw_pos = kw_pos + 3'd1;
					if (kw_pos >= kw_text[kw_sel].len()) begin
						put_token(K_TRUE + {2'b00, kw_sel}, 8'h00, 1'b0);
						lx_mode = M_START;
					end
				end
			end
			M_NUMBER: begin
				if (number_fits(c)) begin
					put_token(K_NUMBER, c, 1'b1);
				end else begin
					put_token(K_NUMBER, 8'h00, 1'b0);
					lx_mode = M_START;
					num_phase = P_INT;
					lex_begin(c);
				end
			end
			default: ;
		endcase
	endfunction

	// Runs an accepted beat through the checker's lexer, queuing tokens or typed_res.
	function automatic void lex_beat(input logic [7:0] c, input logic eoi);
		beat_tokens.delete();
		if (eoi) begin
			case (lx_mode)
				M_NUMBER: put_token(K_NUMBER, 8'h00, 1'b0);
				M_STRING, M_ESCAPE, M_HEX, M_LITERAL: put_token(K_ERROR, 8'h00, 1'b0);
				default: ;
			endcase
			put_token(K_EOF, 8'h00, 1'b0);
			clear_lexer();
		end else begin
			lex_char(c);
		end
		if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size() - 1].last = 1'b1;
		if (use_typed) begin
			pending_tokens = {pending_tokens, typed_res};
		end else begin
			pending_tokens = {pending_tokens, beat_tokens};
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_tokens.size() == 0) begin
					report_mismatch("token beat with nothing pending", token_kind, 0);
				end else begin
					want = pending_tokens.pop_front();
					if (token_kind !== want.kind) report_mismatch("token_kind", token_kind, want.kind);
					if (data_byte !== want.data) report_mismatch("data_byte", data_byte, want.data);
					if (is_content !== want.content)
						report_mismatch("is_content", is_content, want.content);
					if (last !== want.last) report_mismatch("last", last, want.last);
					if (want.kind == K_EOF) eof_seen++;
					if (want.kind == K_ERROR) error_tokens++;
					tokens_checked++;
				end
			end
			if (in_valid && !in_stall) lex_beat(in_byte, end_of_input);
		end
	end

	// Receiver back-pressure: short and long stalls mixed with calm stretches.
	initial begin : stall_gen
		int hold;
		bit level;
		hold = 0;
		level = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				level = !level;
				if (level)
					hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				else
					hold = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			end
			hold--;
			out_stall <= level && !draining;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic eoi, input bit typed,
			input result_t tr);
		int gap;
		int pick;
		pick = $urandom_range(0, 19);
		gap = (pick == 0) ? $urandom_range(10, 30) : (pick < 12) ? 0 : $urandom_range(1, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_input <= eoi;
		use_typed <= typed;
		typed_res <= tr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	function automatic void add(input logic [7:0] b);
		logic [8:0] entry;
		entry = {1'b0, b};
		doc_q = {doc_q, entry};
	endfunction

	function automatic void add_space();
		logic [7:0] ws [4] = '{" ", 8'h09, 8'h0A, 8'h0D};
		repeat ($urandom_range(0, 2)) add(ws[$urandom_range(0, 3)]);
	endfunction

	function automatic void add_hex(input logic [3:0] v);
		bit upper;
		upper = 1'($urandom_range(0, 1));
		if (v < 10) add(8'h30 + {4'h0, v});
		else add((upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10);
	endfunction

	function automatic void add_string();
		string simple;
		logic [7:0] b;
		logic [15:0] cp;
		int sel;
		simple = "bfnrt\"\\/";
		add(8'h22);
		repeat ($urandom_range(0, 6)) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				b = 8'($urandom_range(0, 255));
				if (b == 8'h22 || b == 8'h5C) b = b ^ 8'h01;
				add(b);
			end else if (sel < 6) begin
				add(8'h5C);
				add(simple[$urandom_range(0, 7)]);
			end else if (sel == 6) begin
				b = 8'($urandom_range(0, 255));
				if (b == "u") b = "v";
				add(8'h5C);
				add(b);
			end else begin
				case ($urandom_range(0, 2))
					0: cp = 16'($urandom_range(0, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					default: cp = 16'($urandom_range(0, 16'hFFFF));
				endcase
				add(8'h5C);
				add("u");
				for (int i = 3; i >= 0; i--) begin
					// Now and then a non-hex character breaks the escape.
					if ($urandom_range(0, 24) == 0) add("g");
					else add_hex(cp[i*4 +: 4]);
				end
			end
		end
		add(8'h22);
	endfunction

	function automatic void add_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) add(8'h30 + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void add_number();
		if ($urandom_range(0, 2) == 0) add("-");
		add_digits(1, 3);
		if ($urandom_range(0, 1)) begin
			add(".");
			add_digits(0, 2);
		end
		if ($urandom_range(0, 2) == 0) begin
			add($urandom_range(0, 1) ? "e" : "E");
			case ($urandom_range(0, 2))
				0: add("+");
				1: add("-");
				default: ;
			endcase
			add_digits(0, 2);
		end
	endfunction

	function automatic void add_word();
		int w;
		int cut;
		logic [7:0] bad;
		w = $urandom_range(0, 2);
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, kw_text[w].len() - 1) : 0;
		for (int i = 0; i < kw_text[w].len(); i++) begin
			if (i == cut && cut != 0) begin
				bad = 8'($urandom_range(0, 255));
				if (bad == kw_text[w][i]) bad = bad ^ 8'h01;
				add(bad);
				break;
			end
			add(kw_text[w][i]);
		end
	endfunction

	// A document: a run of tokens with optional whitespace, sometimes cut short,
	// closed by an end-of-input beat.
	function automatic void build_document();
		logic [7:0] punct [6] = '{"{", "}", "[", "]", ":", ","};
		int sel;
		int keep;
		logic [8:0] eoi_entry;
		doc_q.delete();
		repeat ($urandom_range(1, 12)) begin
			add_space();
			sel = $urandom_range(0, 19);
			if (sel < 7) add(punct[$urandom_range(0, 5)]);
			else if (sel < 12) add_string();
			else if (sel < 16) add_number();
			else if (sel < 19) add_word();
			else add(8'($urandom_range(0, 255)));
		end
		add_space();
		if ($urandom_range(0, 7) == 0 && doc_q.size() > 1) begin
			keep = $urandom_range(1, doc_q.size() - 1);
			while (doc_q.size() > keep) void'(doc_q.pop_back());
		end
		eoi_entry = {1'b1, 8'($urandom_range(0, 255))};
		doc_q = {doc_q, eoi_entry};
	endfunction

	initial begin : stimulus
		result_t tr;
		int guard;
		script = '{
			'{8'h00, 1'b0, TYPED,     K_ERROR,    8'h00, 1'b0},
			'{8'hFF, 1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{8'h00, 1'b1, TYPED,     K_EOF,      8'h00, 1'b0},
			'{"{",   1'b0, TYPED,     K_LBRACE,   8'h00, 1'b0},
			'{"[",   1'b0, TYPED,     K_LBRACKET, 8'h00, 1'b0},
			'{"]",   1'b0, TYPED,     K_RBRACKET, 8'h00, 1'b0},
			'{":",   1'b0, TYPED,     K_COLON,    8'h00, 1'b0},
			'{",",   1'b0, TYPED,     K_COMMA,    8'h00, 1'b0},
			'{"}",   1'b0, TYPED,     K_RBRACE,   8'h00, 1'b0},
			'{8'h22, 1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{8'h5C, 1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"n",   1'b0, TYPED,     K_STRING,   8'h0A, 1'b1},
			'{8'h5C, 1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"u",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"F",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"f",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"f",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"F",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{8'h22, 1'b0, TYPED,     K_STRING,   8'h00, 1'b0},
			'{"-",   1'b0, TYPED,     K_NUMBER,   8'h2D, 1'b1},
			'{"e",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"+",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"]",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"n",   1'b0, PREDICTED, K_ERROR,    8'h00, 1'b0},
			'{"x",   1'b0, TYPED,     K_ERROR,    8'h00, 1'b0},
			'{8'hA5, 1'b1, TYPED,     K_EOF,      8'h00, 1'b0}
		};
		errors = 0;
		beats_sent = 0;
		tokens_checked = 0;
		eof_seen = 0;
		error_tokens = 0;
		documents = 0;
		draining = 1'b0;
		use_typed = 1'b0;
		typed_res = '0;
		clear_lexer();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_input = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			tr.kind = script[i].kind;
			tr.data = script[i].data;
			tr.content = script[i].content;
			tr.last = 1'b1;
			send_beat(script[i].text, script[i].eoi, script[i].typed, tr);
		end

		tr = '0;
		while (beats_sent < TOTAL_BEATS) begin
			build_document();
			documents++;
			foreach (doc_q[i]) send_beat(doc_q[i][7:0], doc_q[i][8], PREDICTED, tr);
		end
		in_valid <= 1'b0;
		draining = 1'b1;

		guard = 0;
		while (pending_tokens.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (pending_tokens.size() != 0)
			report_mismatch("tokens never delivered", pending_tokens.size(), 0);

		$display("testbench: %0d input beats in %0d random documents plus a directed script,",
			beats_sent, documents);
		$display("testbench: %0d token beats checked, %0d eof and %0d error tokens among them",
			tokens_checked, eof_seen, error_tokens);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/jtl_pkg.sv
rtl/jtl_step.sv
rtl/jtl_fifo.sv
rtl/json_token_lexer_top.sv
dv/testbench.sv
